/* sv/wait_counter_with_waiter_slots_top_assert.svh */
// Assertion macros for the RTL of the wait counter block (included by wcws_back).
// Each macro checks a property on the rising clock edge outside reset.
`ifndef WAIT_COUNTER_WITH_WAITER_SLOTS_TOP_ASSERT_SVH
`define WAIT_COUNTER_WITH_WAITER_SLOTS_TOP_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define WCWS_ASSERT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: label");
// Next-cycle implication.
`define WCWS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: label");
`else
`define WCWS_ASSERT(label, clk, rstn, ante, cons)
`define WCWS_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

/* sv/wcws_pkg.sv */
// ============================================================================
// wcws_pkg
// Shared types and constants of the wait counter with waiter slots.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package wcws_pkg;

    localparam int SLOTS       = 8;
    localparam int SLOT_IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int COUNT_W     = 32;
    localparam int ID_W        = 16;
    localparam int TAG_W       = 8;
    localparam int QUEUE_DEPTH = 2;

    // Input function codes.
    localparam logic [1:0] FUNC_ADD  = 2'd0;
    localparam logic [1:0] FUNC_SUB  = 2'd1;
    localparam logic [1:0] FUNC_WAIT = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_RELEASE = 2'd0;
    localparam logic [1:0] KIND_COUNT   = 2'd1;
    localparam logic [1:0] KIND_WAIT    = 2'd2;

    // Registration answers.
    localparam logic [1:0] WS_WAITING = 2'd0;
    localparam logic [1:0] WS_READY   = 2'd1;
    localparam logic [1:0] WS_FULL    = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_WAIT
    } op_t;

    // One classified command handed from the front to the back.
    typedef struct packed {
        op_t                 op;
        logic [COUNT_W-1:0]  amount;
        logic [ID_W-1:0]     waiter_id;
        logic [COUNT_W-1:0]  target;
        logic [TAG_W-1:0]    tag;
    } q_item_t;

    // Queue handshake between the two halves.
    typedef struct packed {
        logic    valid;
        q_item_t item;
    } q_out_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [COUNT_W-1:0] prev;
        logic [ID_W-1:0]    id;
        logic [TAG_W-1:0]   tag;
        logic [1:0]         status;
        logic               last;
    } result_t;

endpackage

`default_nettype wire

/* sv/wait_counter_with_waiter_slots_top.sv */
// ============================================================================
// wait_counter_with_waiter_slots_top
// Wrapping 32-bit counter with a table of waiter slots released on a match.
// ============================================================================
//
//  Channel   Ports                               Direction   Moves
//  -------   ---------------------------------   ---------   ---------------------
//  input     s_valid/s_ready, s_func..s_waiter_tag  in       one command transaction
//  result    m_valid/m_ready, m_kind..m_last     out         one result transaction
//
// An add or subtract runs through the execution unit in steps: counter
// update, a compare scan over the slots one at a time, and the final
// record; a stalled output holds a matching scan step and the record. A
// waiter registration is a single step. The sequential slot scan sets the rate.
// Reset (aresetn low, synchronous) clears the counter, frees every slot and
// empties the command queue and the output register.
// The two-entry command queue lets new transactions be accepted while the
// execution unit waits on a stalled result channel.
//
// Slot contents (target, id, tag) are not reset; they are only ever read
// while the matching busy bit is set, so their power-up value never shows.
// Function code 3 is accepted and dropped without any result transaction.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module wait_counter_with_waiter_slots_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_func,
    input  wire logic [31:0] s_amount,
    input  wire logic [15:0] s_waiter_id,
    input  wire logic [31:0] s_target_value,
    input  wire logic [7:0]  s_waiter_tag,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [31:0]      m_previous_count,
    output logic [15:0]      m_released_id,
    output logic [7:0]       m_released_tag,
    output logic [1:0]       m_wait_status,
    output logic             m_last
);
    import wcws_pkg::*;

    // Classified command at the head of the queue, and its pop strobe.
    q_out_t q_out;
    logic   q_pop;

    // Front: accepts transactions, decodes the function, queues commands.
    wcws_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_amount       (s_amount),
        .s_waiter_id    (s_waiter_id),
        .s_target_value (s_target_value),
        .s_waiter_tag   (s_waiter_tag),
        .q_out          (q_out),
        .q_pop          (q_pop)
    );

    // Back: owns the counter and slot table and drives the result channel
    // from its output register.
    wcws_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_out            (q_out),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_previous_count (m_previous_count),
        .m_released_id    (m_released_id),
        .m_released_tag   (m_released_tag),
        .m_wait_status    (m_wait_status),
        .m_last           (m_last)
    );

endmodule

`default_nettype wire

/* sv/wcws_front.sv */
// ============================================================================
// wcws_front
// Accepts input transactions, decodes the function and queues commands.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module wcws_front (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [1:0]               s_func,
    input  wire logic [31:0]              s_amount,
    input  wire logic [15:0]              s_waiter_id,
    input  wire logic [31:0]              s_target_value,
    input  wire logic [7:0]               s_waiter_tag,
    output wcws_pkg::q_out_t              q_out,
    input  wire logic                     q_pop
);
    import wcws_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_item_t           queue_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              push;
    op_t               dec_op;
    q_item_t           new_item;

    assign s_ready = (fill_reg != CNT_W'(QUEUE_DEPTH));

    // The unused function code is accepted and dropped here.
    always_comb begin
        dec_op = OP_ADD;
        push   = 1'b0;
        unique case (s_func)
            FUNC_ADD: begin
                dec_op = OP_ADD;
                push   = 1'b1;
            end
            FUNC_SUB: begin
                dec_op = OP_SUB;
                push   = 1'b1;
            end
            FUNC_WAIT: begin
                dec_op = OP_WAIT;
                push   = 1'b1;
            end
            default: begin
                push = 1'b0;
            end
        endcase
        push = push && s_valid && s_ready;
    end

    always_comb begin
        new_item.op        = dec_op;
        new_item.amount    = s_amount;
        new_item.waiter_id = s_waiter_id;
        new_item.target    = s_target_value;
        new_item.tag       = s_waiter_tag;
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (!push && q_pop) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= new_item;
        end
    end

    assign q_out.valid = (fill_reg != '0);
    assign q_out.item  = queue_mem[rd_ptr_reg];

endmodule

`default_nettype wire

/* sv/wcws_back.sv */
// ============================================================================
// wcws_back
// Executes queued commands: counter update, slot scan, waiter registration.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "wait_counter_with_waiter_slots_top_assert.svh"

module wcws_back (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire wcws_pkg::q_out_t         q_out,
    output logic                          q_pop,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [1:0]                    m_kind,
    output logic [31:0]                   m_previous_count,
    output logic [15:0]                   m_released_id,
    output logic [7:0]                    m_released_tag,
    output logic [1:0]                    m_wait_status,
    output logic                          m_last
);
    import wcws_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [COUNT_W-1:0]     prev_reg, prev_next;
    logic [SLOT_IDX_W-1:0]  idx_reg, idx_next;
    logic [SLOTS-1:0]       busy_reg, busy_next;
    logic [COUNT_W-1:0]     slot_target_mem [SLOTS];
    logic [ID_W-1:0]        slot_waiter_mem [SLOTS];
    logic [TAG_W-1:0]       slot_tag_mem [SLOTS];
    result_t                out_reg;
    logic                   out_valid_reg;
    result_t                res;
    logic                   out_load;
    logic                   out_free;
    logic                   scan_hit;
    logic                   advance;
    logic                   slot_we;
    logic                   free_found;
    logic [SLOT_IDX_W-1:0]  free_idx;

    assign out_free = !out_valid_reg || m_ready;
    assign scan_hit = busy_reg[idx_reg] && (slot_target_mem[idx_reg] == count_reg);

    // Lowest free slot.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_IDX_W'(i);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        prev_next  = prev_reg;
        idx_next   = idx_reg;
        busy_next  = busy_reg;
        q_pop      = 1'b0;
        out_load   = 1'b0;
        slot_we    = 1'b0;
        advance    = 1'b0;
        res        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_out.valid) begin
                    if (q_out.item.op == OP_WAIT) begin
                        if (out_free) begin
                            q_pop      = 1'b1;
                            out_load   = 1'b1;
                            res.kind   = KIND_WAIT;
                            res.last   = 1'b1;
                            if (!free_found) begin
                                res.status = WS_FULL;
                            end else if (q_out.item.target == count_reg) begin
                                res.status = WS_READY;
                            end else begin
                                res.status          = WS_WAITING;
                                busy_next[free_idx] = 1'b1;
                                slot_we             = 1'b1;
                            end
                        end
                    end else begin
                        q_pop      = 1'b1;
                        prev_next  = count_reg;
                        count_next = (q_out.item.op == OP_SUB) ?
                                     count_reg - q_out.item.amount :
                                     count_reg + q_out.item.amount;
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                advance = 1'b1;
                if (scan_hit) begin
                    if (out_free) begin
                        out_load           = 1'b1;
                        res.kind           = KIND_RELEASE;
                        res.id             = slot_waiter_mem[idx_reg];
                        res.tag            = slot_tag_mem[idx_reg];
                        busy_next[idx_reg] = 1'b0;
                    end else begin
                        advance = 1'b0;
                    end
                end
                if (advance) begin
                    if (idx_reg == SLOT_IDX_W'(SLOTS - 1)) begin
                        state_next = ST_DONE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    res.kind   = KIND_COUNT;
                    res.prev   = prev_reg;
                    res.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            busy_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            busy_reg  <= busy_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prev_reg <= prev_next;
        idx_reg  <= idx_next;
        if (out_load) begin
            out_reg <= res;
        end
        if (slot_we) begin
            slot_target_mem[free_idx] <= q_out.item.target;
            slot_waiter_mem[free_idx] <= q_out.item.waiter_id;
            slot_tag_mem[free_idx]    <= q_out.item.tag;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_kind           = out_reg.kind;
    assign m_previous_count = out_reg.prev;
    assign m_released_id    = out_reg.id;
    assign m_released_tag   = out_reg.tag;
    assign m_wait_status    = out_reg.status;
    assign m_last           = out_reg.last;

    `WCWS_ASSERT(a_pop_only_idle, aclk, aresetn, q_pop, state_reg == ST_IDLE)
    `WCWS_ASSERT(a_release_in_scan, aclk, aresetn, out_load && (res.kind == KIND_RELEASE), state_reg == ST_SCAN)
    `WCWS_ASSERT(a_last_on_final, aclk, aresetn, out_load, res.last == (res.kind != KIND_RELEASE))
    `WCWS_ASSERT_NXT(a_one_slot_taken, aclk, aresetn, 1'b1, $countones(busy_reg) <= $countones($past(busy_reg)) + 1)
    `WCWS_ASSERT_NXT(a_count_stable_idle, aclk, aresetn, (state_reg != ST_IDLE) || !q_out.valid, $stable(count_reg))

endmodule

`default_nettype wire
